>>> rtl/double_width_mul_div_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the double-width multiply/divide unit.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_WIDTH_MUL_DIV_UNIT_DEFINES_SVH
`define DOUBLE_WIDTH_MUL_DIV_UNIT_DEFINES_SVH

// Implication checked at every clock edge once reset is released.
`define DWMD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked at every edge, reset included.
`define DWMD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/dwmd_pkg.sv
// ---------------------------------------------------------------------------
// dwmd_pkg
// Shared constants and types of the double-width multiply/divide unit.
// ---------------------------------------------------------------------------
`default_nettype none
package dwmd_pkg;
  localparam int CELL_BITS_DEF = 32;
  localparam int WORD_BITS     = 32;
  localparam int OP_BITS       = 2;

  localparam logic [OP_BITS-1:0] OP_UMUL = 2'd0;
  localparam logic [OP_BITS-1:0] OP_SMUL = 2'd1;
  localparam logic [OP_BITS-1:0] OP_UDIV = 2'd2;
  // Unused code: every result field reads as zero.
  localparam logic [OP_BITS-1:0] OP_NONE = 2'd3;
endpackage
`default_nettype wire

>>> rtl/dwmd_div_stage.sv
// ---------------------------------------------------------------------------
// dwmd_div_stage
// A few restoring division steps on a partial remainder and quotient,
// followed by a register. Chained stages form the divide pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
module dwmd_div_stage
  import dwmd_pkg::*;
#(
  parameter int CB    = CELL_BITS_DEF,
  parameter int STEPS = 4
) (
  input  wire logic            clk,
  input  wire logic [CB-1:0]   rem_in,
  input  wire logic [2*CB-1:0] quo_in,
  input  wire logic [CB-1:0]   dvs_in,
  output logic      [CB-1:0]   rem_r,
  output logic      [2*CB-1:0] quo_r,
  output logic      [CB-1:0]   dvs_r
);
  logic [CB-1:0]   rem_nxt;
  logic [2*CB-1:0] quo_nxt;

  // Each step shifts one dividend bit in from the top of the quotient word.
  always_comb begin
    logic [CB:0] trial;
    rem_nxt = rem_in;
    quo_nxt = quo_in;
    for (int i = 0; i < STEPS; i++) begin
      trial = {rem_nxt, quo_nxt[2*CB-1]};
      quo_nxt = {quo_nxt[2*CB-2:0], 1'b0};
      if (trial >= {1'b0, dvs_in}) begin
        trial = trial - {1'b0, dvs_in};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = trial[CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_in;
  end
endmodule
`default_nettype wire

>>> rtl/dwmd_mul_path.sv
// ---------------------------------------------------------------------------
// dwmd_mul_path
// Multiply path: magnitudes, product, optional negation, delay to align
// with the divide pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
module dwmd_mul_path
  import dwmd_pkg::*;
#(
  parameter int CB    = CELL_BITS_DEF,
  parameter int DELAY = 2
) (
  input  wire logic            clk,
  input  wire logic            is_signed,
  input  wire logic [CB-1:0]   a_in,
  input  wire logic [CB-1:0]   b_in,
  output logic      [2*CB-1:0] prod_out
);
  logic [CB-1:0]   ma_r, mb_r;
  logic            neg_r, neg2_r;
  logic [2*CB-1:0] p_r;
  logic [2*CB-1:0] dly_r [DELAY];

  always_ff @(posedge clk) begin
    ma_r  <= (is_signed && a_in[CB-1]) ? (~a_in + 1'b1) : a_in;
    mb_r  <= (is_signed && b_in[CB-1]) ? (~b_in + 1'b1) : b_in;
    neg_r <= is_signed && (a_in[CB-1] ^ b_in[CB-1]);
    p_r    <= {{CB{1'b0}}, ma_r} * {{CB{1'b0}}, mb_r};
    neg2_r <= neg_r;
    dly_r[0] <= neg2_r ? (~p_r + 1'b1) : p_r;
    for (int i = 1; i < DELAY; i++) dly_r[i] <= dly_r[i-1];
  end

  assign prod_out = dly_r[DELAY-1];
endmodule
`default_nettype wire

>>> rtl/double_width_mul_div_unit.sv
// Throughput: one transaction per cycle.
// The divide runs through CELL_BITS/2 register stages of four restoring
// steps each, after one input register; the multiply path is delayed to match.
// Reset (synchronous, rst_n low) clears the valid bits only.
// The receiver cannot stall: every result shows for exactly one cycle.
// ---------------------------------------------------------------------------
// double_width_mul_div_unit
// Double-cell multiply (unsigned, signed) and double-by-single divide.
// ---------------------------------------------------------------------------
`default_nettype none
`include "double_width_mul_div_unit_defines.svh"
module double_width_mul_div_unit
  import dwmd_pkg::*;
#(
  parameter int CELL_BITS = CELL_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [OP_BITS-1:0]   in_operation,
  input  wire logic [WORD_BITS-1:0] in_top_word,
  input  wire logic [WORD_BITS-1:0] in_next_word,
  input  wire logic [WORD_BITS-1:0] in_third_word,
  output logic                      out_valid,
  output logic [WORD_BITS-1:0]      out_low_word,
  output logic [WORD_BITS-1:0]      out_high_word,
  output logic [WORD_BITS-1:0]      out_remainder_word,
  output logic                      out_divide_by_zero
);
  localparam int CB     = CELL_BITS;
  localparam int STEPS  = 4;
  localparam int NSTAGE = (2*CB + STEPS - 1) / STEPS;
  // Stage 0 registers the inputs, then NSTAGE divide stages, then output.
  localparam int LAT    = NSTAGE + 1;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    logic               dz;
  } ctl_t;

  // Pipeline has no stall: it never refuses a transaction.
  assign busy = 1'b0;
  logic accept;
  assign accept = start && !busy;

  // Input register stage.
  logic          v0_r;
  ctl_t          c0_r;
  logic [CB-1:0] t0_r, n0_r, th0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
    c0_r.op <= in_operation;
    c0_r.dz <= (in_operation == OP_UDIV) && (in_top_word[CB-1:0] == '0);
    t0_r    <= in_top_word[CB-1:0];
    n0_r    <= in_next_word[CB-1:0];
    th0_r   <= in_third_word[CB-1:0];
  end

  // Divide pipeline. A divisor of zero is replaced by one so the stages
  // stay well defined; the result is forced to zero at the output.
  logic [CB-1:0]   rem_s [NSTAGE+1];
  logic [2*CB-1:0] quo_s [NSTAGE+1];
  logic [CB-1:0]   dvs_s [NSTAGE+1];
  assign rem_s[0] = '0;
  assign quo_s[0] = {n0_r, th0_r};
  assign dvs_s[0] = c0_r.dz ? CB'(1) : t0_r;

  for (genvar g = 0; g < NSTAGE; g++) begin : g_div
    localparam int ST = (2*CB - g*STEPS < STEPS) ? (2*CB - g*STEPS) : STEPS;
    dwmd_div_stage #(.CB(CB), .STEPS(ST)) u_stage (
      .clk   (clk),
      .rem_in(rem_s[g]),
      .quo_in(quo_s[g]),
      .dvs_in(dvs_s[g]),
      .rem_r (rem_s[g+1]),
      .quo_r (quo_s[g+1]),
      .dvs_r (dvs_s[g+1])
    );
  end

  // Multiply path, delayed to match the divide stages.
  logic [2*CB-1:0] prod;
  dwmd_mul_path #(.CB(CB), .DELAY(NSTAGE - 2)) u_mul (
    .clk      (clk),
    .is_signed(c0_r.op == OP_SMUL),
    .a_in     (t0_r),
    .b_in     (n0_r),
    .prod_out (prod)
  );

  // Valid and control travel alongside the data.
  logic v_r   [NSTAGE];
  ctl_t c_r   [NSTAGE];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTAGE; i++) v_r[i] <= 1'b0;
    end else begin
      v_r[0] <= v0_r;
      for (int i = 1; i < NSTAGE; i++) v_r[i] <= v_r[i-1];
    end
    c_r[0] <= c0_r;
    for (int i = 1; i < NSTAGE; i++) c_r[i] <= c_r[i-1];
  end

  ctl_t cf;
  assign cf = c_r[NSTAGE-1];
  assign out_valid = v_r[NSTAGE-1];

  always_comb begin
    out_low_word       = '0;
    out_high_word      = '0;
    out_remainder_word = '0;
    out_divide_by_zero = 1'b0;
    case (cf.op)
      OP_UMUL, OP_SMUL: begin
        out_low_word  = WORD_BITS'(prod[CB-1:0]);
        out_high_word = WORD_BITS'(prod[2*CB-1:CB]);
      end
      OP_UDIV: begin
        if (cf.dz) begin
          out_divide_by_zero = 1'b1;
        end else begin
          out_low_word       = WORD_BITS'(quo_s[NSTAGE][CB-1:0]);
          out_high_word      = WORD_BITS'(quo_s[NSTAGE][2*CB-1:CB]);
          out_remainder_word = WORD_BITS'(rem_s[NSTAGE]);
        end
      end
      default: ;
    endcase
  end

  // Terms for the divide-by-zero check.
  logic dz_hit, out_words_zero;
  assign dz_hit         = out_valid && out_divide_by_zero;
  assign out_words_zero = (out_low_word == '0) && (out_high_word == '0) &&
                          (out_remainder_word == '0);

  `DWMD_ASSERT(a_lat, clk, rst_n, accept |-> ##LAT out_valid, "result did not appear after latency")
  `DWMD_ASSERT(a_nospur, clk, rst_n, out_valid |-> $past(accept, LAT), "result without a transaction")
  `DWMD_ASSERT_ALWAYS(a_busy, clk, !busy, "busy asserted")
  `DWMD_ASSERT(a_dz, clk, rst_n, dz_hit |-> out_words_zero, "nonzero result on divide by zero")
endmodule
`default_nettype wire

>>> sim/double_width_mul_div_unit_checker.sv
// ---------------------------------------------------------------------------
// Result checker for the double-width multiply/divide unit
// Watches accepted transactions, predicts each result and
// compares every result field against the oldest pending prediction.
// ---------------------------------------------------------------------------
`default_nettype none
module double_width_mul_div_unit_checker
  import dwmd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire logic [OP_BITS-1:0]   in_operation,
  input  wire logic [WORD_BITS-1:0] in_top_word,
  input  wire logic [WORD_BITS-1:0] in_next_word,
  input  wire logic [WORD_BITS-1:0] in_third_word,
  input  wire logic                 out_valid,
  input  wire logic [WORD_BITS-1:0] out_low_word,
  input  wire logic [WORD_BITS-1:0] out_high_word,
  input  wire logic [WORD_BITS-1:0] out_remainder_word,
  input  wire logic                 out_divide_by_zero,
  output int                        error_count,
  output int                        pending_count
);
  typedef struct packed {
    logic [WORD_BITS-1:0] low_word;
    logic [WORD_BITS-1:0] high_word;
    logic [WORD_BITS-1:0] remainder_word;
    logic                 divide_by_zero;
  } arith_result_t;

  arith_result_t pending_results[$];

  function automatic arith_result_t compute_arith(logic [OP_BITS-1:0] op,
      logic [31:0] t, logic [31:0] n, logic [31:0] th);
    arith_result_t r;
    logic [63:0] a, b, p, dividend, q;
    logic negate;
    r = '0;
    if (op == OP_UMUL || op == OP_SMUL) begin
      a = {32'd0, t};
      b = {32'd0, n};
      negate = 1'b0;
      if (op == OP_SMUL) begin
        negate = t[31] ^ n[31];
        if (t[31]) a = {32'd0, -t};
        if (n[31]) b = {32'd0, -n};
      end
      p = a * b;
      if (negate) p = -p;
      r.low_word  = p[31:0];
      r.high_word = p[63:32];
    end else if (op == OP_UDIV) begin
      if (t == 32'd0) begin
        r.divide_by_zero = 1'b1;
      end else begin
        dividend = {n, th};
        q = dividend / {32'd0, t};
        r.remainder_word = 32'(dividend % {32'd0, t});
        r.low_word  = q[31:0];
        r.high_word = q[63:32];
      end
    end
    return r;
  endfunction

  assign pending_count = pending_results.size();

  always @(posedge clk) begin
    arith_result_t got, want;
    if (!rst_n) begin
      error_count <= 0;
    end else begin
      if (start && !busy)
        pending_results.push_back(compute_arith(in_operation, in_top_word,
                                                in_next_word, in_third_word));
      if (out_valid) begin
        got = {out_low_word, out_high_word, out_remainder_word, out_divide_by_zero};
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          error_count <= error_count + 1;
        end else begin
          want = pending_results.pop_front();
          if (got.low_word !== want.low_word)
            $display("%0t: low_word expected %h actual %h", $time,
                     want.low_word, got.low_word);
          if (got.high_word !== want.high_word)
            $display("%0t: high_word expected %h actual %h", $time,
                     want.high_word, got.high_word);
          if (got.remainder_word !== want.remainder_word)
            $display("%0t: remainder_word expected %h actual %h", $time,
                     want.remainder_word, got.remainder_word);
          if (got.divide_by_zero !== want.divide_by_zero)
            $display("%0t: divide_by_zero expected %b actual %b", $time,
                     want.divide_by_zero, got.divide_by_zero);
          if (got !== want) error_count <= error_count + 1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> sim/double_width_mul_div_unit_tb.sv
// ---------------------------------------------------------------------------
// Testbench for the double-width multiply/divide unit
// Drives directed corner transactions and then random ones with random gaps;
// a separate checker predicts and compares every result.
// ---------------------------------------------------------------------------
`default_nettype none
module double_width_mul_div_unit_tb;
  import dwmd_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  // The pipeline is CELL_BITS/2 + 1 deep; this covers it with margin.
  localparam int DRAIN_CYCLES = 20;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [OP_BITS-1:0]   in_operation = OP_UMUL;
  logic [WORD_BITS-1:0] in_top_word = '0;
  logic [WORD_BITS-1:0] in_next_word = '0;
  logic [WORD_BITS-1:0] in_third_word = '0;
  logic                 out_valid;
  logic [WORD_BITS-1:0] out_low_word, out_high_word, out_remainder_word;
  logic                 out_divide_by_zero;
  int                   error_count, pending_count;

  always #5 clk = ~clk;

  double_width_mul_div_unit uut (.*);
  double_width_mul_div_unit_checker checker_i (.*);

  // Presents one transaction and holds it until accepted. Start stays high
  // into the next transaction when no gap is drawn, so it is never lowered
  // and raised within one time step.
  task automatic send_transaction(logic [OP_BITS-1:0] op, logic [31:0] t,
                                  logic [31:0] n, logic [31:0] th);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;  // Stretches of back-to-back traffic.
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_top_word  <= t;
    in_next_word <= n;
    in_third_word <= th;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Operand picker that favors the values where arithmetic corner cases live.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'd1 << $urandom_range(0, 31);
      5: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [OP_BITS-1:0] op;
    logic [31:0] t;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: width extremes, sign combinations, most negative operands,
    // zero divisor, quotients wider than a cell, and the unused operation.
    send_transaction(OP_UMUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_transaction(OP_UMUL, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_transaction(OP_SMUL, 32'h8000_0000, 32'h8000_0000, 32'd0);
    send_transaction(OP_SMUL, 32'h8000_0000, 32'd1, 32'd0);
    send_transaction(OP_SMUL, 32'hFFFF_FFFF, 32'd7, 32'd0);
    send_transaction(OP_SMUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_transaction(OP_SMUL, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
    send_transaction(OP_SMUL, 32'd0, 32'h8000_0000, 32'd0);
    send_transaction(OP_UDIV, 32'd0, 32'd5, 32'd9);
    send_transaction(OP_UDIV, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_transaction(OP_UDIV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_transaction(OP_UDIV, 32'd3, 32'd0, 32'd10);
    send_transaction(OP_UDIV, 32'h8000_0000, 32'd1, 32'd0);
    send_transaction(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_transaction(OP_NONE, 32'd0, 32'd0, 32'd0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      op = ($urandom_range(0, 19) == 0) ? OP_NONE : 2'($urandom_range(0, 2));
      t = pick_word();
      // Zero divisors are kept occasional so real divides dominate.
      if (op == OP_UDIV && t == 32'd0 && $urandom_range(0, 3) != 0) t = $urandom | 1;
      send_transaction(op, t, pick_word(), pick_word());
    end
    start <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0)
      $display("double_width_mul_div_unit_tb: clean");
    else
      $display("double_width_mul_div_unit_tb: errors");
    $finish;
  end

  // Slowest run: about 1715 transactions, each after the largest gap, plus the drain.
  initial begin
    #2000000;
    $display("double_width_mul_div_unit_tb: errors");
    $finish;
  end
endmodule
`default_nettype wire

>>> files.f
+incdir+rtl
rtl/dwmd_pkg.sv
rtl/dwmd_div_stage.sv
rtl/dwmd_mul_path.sv
rtl/double_width_mul_div_unit.sv
sim/double_width_mul_div_unit_checker.sv
sim/double_width_mul_div_unit_tb.sv
